// ===== sv/assert_macros.svh =====
// Assertion macros used by the accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of i_clk while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks an implication at every rising edge of i_clk while reset is released.
`define ASSERT_IMPL(label, pre, post, msg) \
    `ASSERT_CLK(label, (pre) |-> (post), msg)

// Checks that a condition leads to another one in the next cycle.
`define ASSERT_NEXT(label, pre, post, msg) \
    `ASSERT_CLK(label, (pre) |=> (post), msg)

`endif

// ===== sv/tpla_pkg.sv =====
// Package with the types, constants and pair-sum lookup of the ternary pair accumulator.
package tpla_pkg;

    localparam int TILE_CHANNELS = 128;
    localparam int PAIR_COUNT    = TILE_CHANNELS / 2;

    localparam int ACT_W  = 16;
    localparam int SUM_W  = 32;
    localparam int CODE_W = 4;
    localparam int COL_W  = 6;

    // Rows that the column field can actually reach.
    localparam int COL_SPAN = 1 << COL_W;
    localparam int ROWS     = (PAIR_COUNT < COL_SPAN) ? PAIR_COUNT : COL_SPAN;
    localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Weight nibble codes.
    localparam logic [CODE_W-1:0] CODE_NEG_A0_NEG_A1 = 4'd0;
    localparam logic [CODE_W-1:0] CODE_NEG_A0        = 4'd1;
    localparam logic [CODE_W-1:0] CODE_NEG_A0_POS_A1 = 4'd2;
    localparam logic [CODE_W-1:0] CODE_NEG_A1        = 4'd3;
    localparam logic [CODE_W-1:0] CODE_ZERO          = 4'd4;
    localparam logic [CODE_W-1:0] CODE_POS_A1        = 4'd5;
    localparam logic [CODE_W-1:0] CODE_POS_A0_NEG_A1 = 4'd6;
    localparam logic [CODE_W-1:0] CODE_POS_A0        = 4'd7;
    localparam logic [CODE_W-1:0] CODE_POS_A0_POS_A1 = 4'd8;

    typedef struct packed {
        logic signed [ACT_W-1:0] act_even;
        logic signed [ACT_W-1:0] act_odd;
        logic [2*CODE_W-1:0]     weight_byte;
        logic [COL_W-1:0]        column;
        logic                    last_pair;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_even;
        logic signed [SUM_W-1:0] sum_odd;
        logic [COL_W-1:0]        out_column;
    } t_out_item;

    // Selects one of the nine pair sums; all arithmetic wraps at 16 bits.
    function automatic logic signed [ACT_W-1:0] pick_entry(
        input logic [CODE_W-1:0]     code,
        input logic signed [ACT_W-1:0] a0,
        input logic signed [ACT_W-1:0] a1
    );
        logic signed [ACT_W-1:0] v;
        unique case (code)
            CODE_NEG_A0_NEG_A1: v = -a0 - a1;
            CODE_NEG_A0:        v = -a0;
            CODE_NEG_A0_POS_A1: v = a1 - a0;
            CODE_NEG_A1:        v = -a1;
            CODE_ZERO:          v = '0;
            CODE_POS_A1:        v = a1;
            CODE_POS_A0_NEG_A1: v = a0 - a1;
            CODE_POS_A0:        v = a0;
            CODE_POS_A0_POS_A1: v = a0 + a1;
            default:            v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/ternary_pair_lut_accumulator.sv =====
// Ternary pair accumulator top level: pair-sum lookup, accumulator memory and result register.
//
// The block takes one transfer per clock cycle: two 16-bit activations, a weight byte whose low
// nibble codes the even channel and whose high nibble codes the odd channel, a column and a
// last-pair mark. Each nibble selects one of nine pair sums (-a0-a1 through a0+a1, codes nine
// to fifteen select zero), which is sign-extended and added to that channel's 32-bit wrapping
// accumulator. On the last pair of a column the two finished sums, including this pair, leave
// as one result transfer and both accumulators return to zero. Columns at or beyond half the
// tile width are accepted and dropped. The accumulators live in a memory with one row per
// column (even and odd sum side by side); the row is read on the accepting edge and written
// back from stage one, which on a last pair also loads the result register, and a new item
// is taken every cycle unless the input stalls. A back-to-back item for the same column picks
// up the value being written on its accepting edge through a bypass register. Each row has
// a valid flip-flop cleared by reset, so all sums read zero right after reset with no clearing
// pass. The input stalls only when a finished result waits in the stage while the result
// register is still held by a stalled output.
module ternary_pair_lut_accumulator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  tpla_pkg::t_in_item   i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output tpla_pkg::t_out_item  o_out_data,
    input  logic                 i_out_stall
);

`include "assert_macros.svh"

    localparam int ACT_W  = tpla_pkg::ACT_W;
    localparam int SUM_W  = tpla_pkg::SUM_W;
    localparam int CODE_W = tpla_pkg::CODE_W;
    localparam int COL_W  = tpla_pkg::COL_W;
    localparam int ROWS   = tpla_pkg::ROWS;
    localparam int ROW_AW = tpla_pkg::ROW_AW;

    // Accumulator memory: {odd sum, even sum} per column.
    logic [2*SUM_W-1:0] mem [ROWS];
    logic [ROWS-1:0]    r_row_valid;

    // Stage one: registered item, memory read data and bypass.
    logic                    r_s1_valid;
    logic                    r_s1_last;
    logic [COL_W-1:0]        r_s1_col;
    logic [ROW_AW-1:0]       r_s1_row;
    logic signed [ACT_W-1:0] r_s1_add_even;
    logic signed [ACT_W-1:0] r_s1_add_odd;
    logic [2*SUM_W-1:0]      r_rd_data;
    logic                    r_rd_valid;
    logic                    r_s1_byp;
    logic [2*SUM_W-1:0]      r_byp_data;

    // Result register.
    logic                    r_out_valid;
    tpla_pkg::t_out_item     r_out;

    logic                    in_fire;
    logic                    in_range;
    logic [ROW_AW-1:0]       in_row;
    logic                    s1_advance;
    logic                    s1_write;
    logic [2*SUM_W-1:0]      base;
    logic signed [SUM_W-1:0] n_sum_even;
    logic signed [SUM_W-1:0] n_sum_odd;
    logic [2*SUM_W-1:0]      wr_data;

    // Stage one can always move on unless it holds a result and the output is blocked.
    assign s1_advance = !r_s1_valid || !r_s1_last || !r_out_valid || !i_out_stall;
    assign s1_write   = r_s1_valid && s1_advance;
    assign o_in_stall = !s1_advance;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign in_range   = 32'(i_in_data.column) < ROWS;
    assign in_row     = ROW_AW'(i_in_data.column);

    // Base value: bypass beats the memory, an unwritten row reads zero.
    always_comb begin
        if (r_s1_byp) begin
            base = r_byp_data;
        end else if (r_rd_valid) begin
            base = r_rd_data;
        end else begin
            base = '0;
        end
        n_sum_even = $signed(base[SUM_W-1:0]) + SUM_W'(r_s1_add_even);
        n_sum_odd  = $signed(base[2*SUM_W-1:SUM_W]) + SUM_W'(r_s1_add_odd);
        wr_data    = r_s1_last ? '0 : {n_sum_odd, n_sum_even};
    end

    // Memory read on acceptance and write-back from stage one.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_data <= mem[in_row];
        end
        if (s1_write) begin
            mem[r_s1_row] <= wr_data;
        end
    end

    // Stage one payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_last     <= i_in_data.last_pair;
            r_s1_col      <= i_in_data.column;
            r_s1_row      <= in_row;
            r_s1_add_even <= tpla_pkg::pick_entry(i_in_data.weight_byte[CODE_W-1:0],
                                                  i_in_data.act_even, i_in_data.act_odd);
            r_s1_add_odd  <= tpla_pkg::pick_entry(i_in_data.weight_byte[2*CODE_W-1:CODE_W],
                                                  i_in_data.act_even, i_in_data.act_odd);
            r_rd_valid    <= r_row_valid[in_row];
            r_s1_byp      <= s1_write && (r_s1_row == in_row);
            r_byp_data    <= wr_data;
        end
    end

    // Control state: stage valid, row valid bits, result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= in_range;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_write) begin
                r_row_valid[r_s1_row] <= 1'b1;
            end
            if (s1_write && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_write && r_s1_last) begin
            r_out.sum_even   <= n_sum_even;
            r_out.sum_odd    <= n_sum_odd;
            r_out.out_column <= r_s1_col;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The input is held back only by a finished result that cannot leave.
    `ASSERT_IMPL(a_stall_cause, o_in_stall, r_s1_valid && r_s1_last && r_out_valid && i_out_stall,
                 "input stalled without a blocked result")
    // A finished column always lands in the result register.
    `ASSERT_NEXT(a_last_to_out, s1_write && r_s1_last, r_out_valid,
                 "finished column did not reach the result register")
    // A new result only comes from a finished column in stage one.
    `ASSERT_IMPL(a_out_source, $rose(r_out_valid), $past(s1_write && r_s1_last),
                 "result appeared without a finished column")

endmodule
